// File: rtl/core/keyed_record_table_unit_assert.svh
// Assertion macros for the keyed record table unit
`ifndef KEYED_RECORD_TABLE_UNIT_ASSERT_SVH
`define KEYED_RECORD_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication check
`define KRT_CHECK(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication check
`define KRT_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KRT_CHECK(lbl, clk, rst_n, ante, cons, msg)
`define KRT_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/core/krt_pkg.sv
// Shared types and codes for the keyed record table
package krt_pkg;

	// Operation codes on func
	localparam logic [2:0] FN_ADD   = 3'd0;
	localparam logic [2:0] FN_MARK  = 3'd1;
	localparam logic [2:0] FN_CARGO = 3'd2;
	localparam logic [2:0] FN_LOC   = 3'd3;
	localparam logic [2:0] FN_FIND  = 3'd4;

	// Outcome codes
	localparam logic [2:0] OC_ADDED     = 3'd0;
	localparam logic [2:0] OC_UPDATED   = 3'd1;
	localparam logic [2:0] OC_FULL      = 3'd2;
	localparam logic [2:0] OC_NOT_FOUND = 3'd3;
	localparam logic [2:0] OC_FOUND     = 3'd4;

	// Cargo state codes
	localparam logic [1:0] CS_NOT_RECEIVED = 2'd0;
	localparam logic [1:0] CS_RECEIVED     = 2'd1;
	localparam logic [1:0] CS_UNKNOWN      = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} ctrl_state_t;

	// Search token that walks the cell chain
	typedef struct packed {
		logic        vld;
		logic [2:0]  func;
		logic [15:0] key;
		logic [15:0] dline;
		logic [7:0]  x;
		logic [7:0]  y;
		logic        cargo;
		logic        hit;
		logic        free;
		logic [7:0]  hit_x;
		logic [7:0]  hit_y;
		logic        hit_ld;
		logic [15:0] hit_key;
	} token_t;

	// Write broadcast from the controller to the cells
	typedef struct packed {
		logic        en;
		logic        fill;
		logic        ld;
		logic [15:0] key;
		logic [15:0] dline;
		logic [7:0]  x;
		logic [7:0]  y;
	} commit_t;

endpackage

// File: rtl/core/krt_cell.sv
// One table slot: record storage plus one stage of the search chain
module krt_cell import krt_pkg::*; #(
	parameter int IW  = 3,
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  token_t        tok_i,
	input  logic [IW-1:0] hit_idx_i,
	input  logic [IW-1:0] free_idx_i,
	output token_t        tok_o,
	output logic [IW-1:0] hit_idx_o,
	output logic [IW-1:0] free_idx_o,
	input  commit_t       commit_i,
	input  logic [IW-1:0] commit_idx_i
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic        valid_q;
	logic [15:0] key_q;
	logic [15:0] dline_q;
	logic [7:0]  x_q;
	logic [7:0]  y_q;
	logic        ld_q;

	token_t        tok_n;
	logic [IW-1:0] hidx_n;
	logic [IW-1:0] fidx_n;
	logic          cmp;
	logic          sel;

	token_t        tok_s1;
	logic [IW-1:0] hit_idx_s1;
	logic [IW-1:0] free_idx_s1;

	assign sel = commit_i.en && (commit_idx_i == MY_IDX);

	// Match this slot against the passing token
	always_comb begin
		tok_n  = tok_i;
		hidx_n = hit_idx_i;
		fidx_n = free_idx_i;
		if (tok_i.func == FN_FIND) begin
			cmp = (x_q == tok_i.x) && (y_q == tok_i.y);
		end else begin
			cmp = (key_q == tok_i.key);
		end
		if (valid_q && cmp && !tok_i.hit) begin
			tok_n.hit     = 1'b1;
			tok_n.hit_x   = x_q;
			tok_n.hit_y   = y_q;
			tok_n.hit_ld  = ld_q;
			tok_n.hit_key = key_q;
			hidx_n        = MY_IDX;
		end
		if (!valid_q && !tok_i.free) begin
			tok_n.free = 1'b1;
			fidx_n     = MY_IDX;
		end
	end

	// Advance the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1 <= tok_n;
		end
	end

	always_ff @(posedge clk) begin
		hit_idx_s1  <= hidx_n;
		free_idx_s1 <= fidx_n;
	end

	// Mark the slot used on a fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel && commit_i.fill) begin
			valid_q <= 1'b1;
		end
	end

	// Write record fields
	always_ff @(posedge clk) begin
		if (sel) begin
			ld_q <= commit_i.ld;
			if (commit_i.fill) begin
				key_q   <= commit_i.key;
				dline_q <= commit_i.dline;
				x_q     <= commit_i.x;
				y_q     <= commit_i.y;
			end
		end
	end

	assign tok_o      = tok_s1;
	assign hit_idx_o  = hit_idx_s1;
	assign free_idx_o = free_idx_s1;

endmodule

// File: rtl/core/krt_ctrl.sv
// Sequencer: launches searches, decides the result and writes back to the slots
`include "keyed_record_table_unit_assert.svh"
module krt_ctrl import krt_pkg::*; #(
	parameter int SLOT_COUNT = 8,
	parameter int IW         = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  token_t        tail_i,
	input  logic [IW-1:0] tail_hidx_i,
	input  logic [IW-1:0] tail_fidx_i,
	output commit_t       commit_o,
	output logic [IW-1:0] commit_idx_o,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [2:0]    outcome,
	output logic [1:0]    cargo_state,
	output logic [7:0]    found_x,
	output logic [7:0]    found_y,
	output logic [15:0]   found_address,
	output logic [3:0]    slot_used
);

	localparam logic [3:0] SLOT_NONE = 4'(SLOT_COUNT);

	ctrl_state_t state_q, state_n;

	token_t        tail_q;
	logic [IW-1:0] hidx_q;
	logic [IW-1:0] fidx_q;

	logic          out_valid_q;
	logic [2:0]    outcome_q;
	logic [1:0]    cargo_q;
	logic [7:0]    fx_q;
	logic [7:0]    fy_q;
	logic [15:0]   faddr_q;
	logic [3:0]    slot_q;

	logic          out_free;
	logic          out_load;
	logic [IW+3:0] hidx_ext;
	logic [IW+3:0] fidx_ext;

	logic [2:0]    res_outcome;
	logic [1:0]    res_cargo;
	logic [7:0]    res_x;
	logic [7:0]    res_y;
	logic [15:0]   res_addr;
	logic [3:0]    res_slot;

	assign out_free = !out_valid_q || !out_stall;
	assign hidx_ext = {4'b0, hidx_q};
	assign fidx_ext = {4'b0, fidx_q};

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and handshake
	always_comb begin
		state_n  = state_q;
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_n = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (tail_i.vld) begin
					state_n = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Hold the token that left the chain
	always_ff @(posedge clk) begin
		if (tail_i.vld) begin
			tail_q <= tail_i;
			hidx_q <= tail_hidx_i;
			fidx_q <= tail_fidx_i;
		end
	end

	// Decide result and write-back from the finished search
	always_comb begin
		res_outcome  = OC_NOT_FOUND;
		res_cargo    = CS_NOT_RECEIVED;
		res_x        = 8'd0;
		res_y        = 8'd0;
		res_addr     = 16'd0;
		res_slot     = SLOT_NONE;
		commit_o     = '0;
		commit_idx_o = hidx_q;
		commit_o.key   = tail_q.key;
		commit_o.dline = tail_q.dline;
		commit_o.x     = tail_q.x;
		commit_o.y     = tail_q.y;
		unique case (tail_q.func)
			FN_ADD: begin
				if (tail_q.hit) begin
					res_outcome = OC_UPDATED;
					res_slot    = hidx_ext[3:0];
					commit_o.en = out_load;
					commit_o.ld = tail_q.cargo;
				end else if (tail_q.free) begin
					res_outcome   = OC_ADDED;
					res_slot      = fidx_ext[3:0];
					commit_o.en   = out_load;
					commit_o.fill = 1'b1;
					commit_o.ld   = tail_q.cargo;
					commit_idx_o  = fidx_q;
				end else begin
					res_outcome = OC_FULL;
				end
			end
			FN_MARK: begin
				if (tail_q.hit) begin
					res_outcome = OC_FOUND;
					res_slot    = hidx_ext[3:0];
					commit_o.en = out_load;
					commit_o.ld = 1'b1;
				end
			end
			FN_CARGO: begin
				res_cargo = CS_UNKNOWN;
				if (tail_q.hit) begin
					res_outcome = OC_FOUND;
					res_slot    = hidx_ext[3:0];
					res_cargo   = tail_q.hit_ld ? CS_RECEIVED : CS_NOT_RECEIVED;
				end
			end
			FN_LOC: begin
				if (tail_q.hit) begin
					res_outcome = OC_FOUND;
					res_slot    = hidx_ext[3:0];
					res_x       = tail_q.hit_x;
					res_y       = tail_q.hit_y;
				end
			end
			FN_FIND: begin
				if (tail_q.hit) begin
					res_outcome = OC_FOUND;
					res_slot    = hidx_ext[3:0];
					res_addr    = tail_q.hit_key;
				end
			end
			default: begin
				res_outcome = OC_NOT_FOUND;
			end
		endcase
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			outcome_q <= res_outcome;
			cargo_q   <= res_cargo;
			fx_q      <= res_x;
			fy_q      <= res_y;
			faddr_q   <= res_addr;
			slot_q    <= res_slot;
		end
	end

	assign out_valid     = out_valid_q;
	assign outcome       = outcome_q;
	assign cargo_state   = cargo_q;
	assign found_x       = fx_q;
	assign found_y       = fy_q;
	assign found_address = faddr_q;
	assign slot_used     = slot_q;

	`KRT_CHECK(a_tail_in_scan, clk, arst_n, tail_i.vld, state_q == ST_SCAN, "token left chain outside scan")
	`KRT_CHECK_NEXT(a_tail_to_fin, clk, arst_n, tail_i.vld, state_q == ST_FIN, "finished search not held")
	`KRT_CHECK(a_commit_with_result, clk, arst_n, commit_o.en, out_load, "slot write without result transfer")
	`KRT_CHECK(a_full_no_slot, clk, arst_n, out_valid_q && (outcome_q == OC_FULL), slot_q == SLOT_NONE, "full result names a slot")

endmodule

// File: rtl/core/keyed_record_table_unit.sv
// A result is offered after the token has walked all slot cells, been held at the
// chain's tail and loaded into the output register. One search is in flight at a time;
// the token walks the chain one slot per cycle, and slot write-back happens with that load.
// The output register holds a result while the next item is taken in.
// Reset clears every slot's valid mark and all handshake state at once;
// record fields are not reset and are only read behind a valid mark.
module keyed_record_table_unit import krt_pkg::*; #(
	parameter int SLOT_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [15:0] ship_address,
	input  logic [15:0] deadline_value,
	input  logic [7:0]  location_x,
	input  logic [7:0]  location_y,
	input  logic        cargo_flag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  outcome,
	output logic [1:0]  cargo_state,
	output logic [7:0]  found_x,
	output logic [7:0]  found_y,
	output logic [15:0] found_address,
	output logic [3:0]  slot_used
);

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	token_t        tok  [SLOT_COUNT+1];
	logic [IW-1:0] hidx [SLOT_COUNT+1];
	logic [IW-1:0] fidx [SLOT_COUNT+1];
	commit_t       commit;
	logic [IW-1:0] commit_idx;

	// Build the search token at the head of the chain
	always_comb begin
		tok[0]       = '0;
		tok[0].vld   = in_valid && !in_stall;
		tok[0].func  = func;
		tok[0].key   = ship_address;
		tok[0].dline = deadline_value;
		tok[0].x     = location_x;
		tok[0].y     = location_y;
		tok[0].cargo = cargo_flag;
	end

	assign hidx[0] = '0;
	assign fidx[0] = '0;

	// Chain of slot cells
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		krt_cell #(
			.IW  (IW),
			.IDX (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.tok_i        (tok[i]),
			.hit_idx_i    (hidx[i]),
			.free_idx_i   (fidx[i]),
			.tok_o        (tok[i+1]),
			.hit_idx_o    (hidx[i+1]),
			.free_idx_o   (fidx[i+1]),
			.commit_i     (commit),
			.commit_idx_i (commit_idx)
		);
	end

	krt_ctrl #(
		.SLOT_COUNT (SLOT_COUNT),
		.IW         (IW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.tail_i        (tok[SLOT_COUNT]),
		.tail_hidx_i   (hidx[SLOT_COUNT]),
		.tail_fidx_i   (fidx[SLOT_COUNT]),
		.commit_o      (commit),
		.commit_idx_o  (commit_idx),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.outcome       (outcome),
		.cargo_state   (cargo_state),
		.found_x       (found_x),
		.found_y       (found_y),
		.found_address (found_address),
		.slot_used     (slot_used)
	);

endmodule
